### rtl/fdtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtw_pkg
// Types and codes shared by the device-tree structure walker and its cell
// stack.
// ----------------------------------------------------------------------------
package fdtw_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ADDR_OFS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_OFS = 2'd1;

    localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
    localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
    localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
    localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
    localparam logic [31:0] TOK_END        = 32'h0000_0009;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_NODE_BEG  = 3'd1;
    localparam logic [2:0] EV_NODE_END  = 3'd2;
    localparam logic [2:0] EV_PROP      = 3'd3;
    localparam logic [2:0] EV_END       = 3'd4;
    localparam logic [2:0] EV_BAD_TOKEN = 3'd5;
    localparam logic [2:0] EV_OVERFLOW  = 3'd6;
    localparam logic [2:0] EV_AFTER_END = 3'd7;

    typedef struct packed {
        logic [31:0] word;
        logic        first_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0] token_event;
        logic [3:0] tree_depth;
        logic [7:0] addr_cnt;
        logic [7:0] size_cnt;
    } t_out_item;

    typedef struct packed {
        logic [7:0] addr_cnt;
        logic [7:0] size_cnt;
    } t_cells;

    // One operation on the cell stack per accepted item
    typedef struct packed {
        logic       clear;
        logic       push;
        logic       pop;
        logic       set_addr;
        logic       set_size;
        logic [7:0] value;
    } t_stk_op;

endpackage

### rtl/fdt_struct_token_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_struct_token_walker
// Walks a device-tree structure block one 32-bit word per item.
// ----------------------------------------------------------------------------
// Input channel: one structure-block word per item, first_word set on the
// first word of a block to restart the walk. Output channel: exactly one
// result item per input item, giving the token event, the nesting depth after
// the word and the address/size cell counts in force at that depth.
// Configuration channel: register 0 holds the #address-cells name offset,
// register 1 the #size-cells name offset; writes are always taken and other
// indexes are ignored. Write only while the walker is idle.
// Each result is registered into the output queue as its word is accepted.
// Throughput is one word per cycle: the state update is combinational and
// the cell stack memory is read one level ahead, with write forwarding.
// A two-entry output queue lets the walker take a word while a result waits;
// when the receiver stalls with both entries full, input ready drops.
// Reset clears the walk state, both name offsets and the output queue; the
// stack memory needs no clearing pass since levels are written before read.
// ----------------------------------------------------------------------------
module fdt_struct_token_walker #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  fdtw_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output fdtw_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fdtw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import fdtw_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH);
    localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH - 1);

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_NAME,
        PH_LEN,
        PH_OFF,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ADDR,
        KIND_SIZE
    } t_kind;

    // configuration
    logic [31:0] r_addr_ofs, r_size_ofs;

    // walk state
    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [30:0] r_words, n_words;
    logic [30:0] r_left, n_left;
    logic        r_long, n_long;
    logic        r_ended, n_ended;
    logic        r_failed, n_failed;

    // output queue
    t_out_item   r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    logic          in_acc, out_acc;
    logic          first;
    logic [31:0]   w;
    logic [2:0]    ev;
    t_stk_op       stk_op;
    logic [DW-1:0] cur_depth, e_depth, nx_depth;
    logic [DW+3:0] depth_ext;
    t_cells        nx_cells;
    t_out_item     res;
    logic          zero_byte;
    logic [7:0]    sat_val;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign first   = i_in_data.first_word;
    assign w       = i_in_data.word;

    assign zero_byte = (w[7:0] == 8'd0) || (w[15:8] == 8'd0) ||
                       (w[23:16] == 8'd0) || (w[31:24] == 8'd0);
    assign sat_val   = (w[31:8] != 24'd0) ? 8'hFF : w[7:0];
    assign e_depth   = first ? '0 : cur_depth;

    always_comb begin
        t_phase e_phase;
        t_kind  e_kind;
        logic   e_ended;
        logic   e_failed;

        e_phase  = first ? PH_TOKEN  : r_phase;
        e_kind   = first ? KIND_NONE : r_kind;
        e_ended  = first ? 1'b0      : r_ended;
        e_failed = first ? 1'b0      : r_failed;

        n_phase  = e_phase;
        n_kind   = e_kind;
        n_words  = r_words;
        n_left   = first ? '0 : r_left;
        n_long   = first ? 1'b0 : r_long;
        n_ended  = e_ended;
        n_failed = e_failed;
        ev       = EV_NONE;
        stk_op   = '0;
        stk_op.clear = first;
        stk_op.value = sat_val;

        if (e_failed) begin
            ev = EV_BAD_TOKEN;
        end else if (e_ended) begin
            ev = EV_AFTER_END;
        end else begin
            case (e_phase)
                PH_NAME: begin
                    if (zero_byte) begin
                        n_phase = PH_TOKEN;
                    end
                end
                PH_LEN: begin
                    n_words = {1'b0, w[31:2]} + 31'(w[1:0] != 2'd0);
                    n_long  = (w[31:2] != 30'd0);
                    n_phase = PH_OFF;
                end
                PH_OFF: begin
                    n_left = r_words;
                    if (r_words == '0) begin
                        n_phase = PH_TOKEN;
                        n_kind  = KIND_NONE;
                    end else begin
                        n_phase = PH_DATA;
                        if (w == r_addr_ofs) begin
                            n_kind = KIND_ADDR;
                        end else if (w == r_size_ofs) begin
                            n_kind = KIND_SIZE;
                        end else begin
                            n_kind = KIND_NONE;
                        end
                    end
                end
                PH_DATA: begin
                    if (r_long) begin
                        stk_op.set_addr = (e_kind == KIND_ADDR);
                        stk_op.set_size = (e_kind == KIND_SIZE);
                    end
                    n_kind = KIND_NONE;
                    n_left = r_left - 31'd1;
                    if (r_left == 31'd1) begin
                        n_phase = PH_TOKEN;
                    end
                end
                default: begin
                    n_phase = PH_TOKEN;
                    case (w)
                        TOK_BEGIN_NODE: begin
                            if (e_depth >= DEPTH_LIMIT) begin
                                n_failed = 1'b1;
                                ev       = EV_OVERFLOW;
                            end else begin
                                stk_op.push = 1'b1;
                                n_phase     = PH_NAME;
                                ev          = EV_NODE_BEG;
                            end
                        end
                        TOK_END_NODE: begin
                            if (e_depth == '0) begin
                                n_failed = 1'b1;
                                ev       = EV_BAD_TOKEN;
                            end else begin
                                stk_op.pop = 1'b1;
                                ev         = EV_NODE_END;
                            end
                        end
                        TOK_PROP: begin
                            n_phase = PH_LEN;
                            ev      = EV_PROP;
                        end
                        TOK_NOP: begin
                            ev = EV_NONE;
                        end
                        TOK_END: begin
                            n_ended = 1'b1;
                            ev      = EV_END;
                        end
                        default: begin
                            n_failed = 1'b1;
                            ev       = EV_BAD_TOKEN;
                        end
                    endcase
                end
            endcase
        end

        // drop the operation unless an item is taken this cycle
        if (!in_acc) begin
            stk_op = '0;
        end
    end

    fdtw_cell_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (stk_op),
        .o_depth      (cur_depth),
        .o_next_depth (nx_depth),
        .o_next_cells (nx_cells)
    );

    assign depth_ext = (DW + 4)'(nx_depth);

    always_comb begin
        res.token_event = ev;
        res.tree_depth  = depth_ext[3:0];
        res.addr_cnt    = nx_cells.addr_cnt;
        res.size_cnt    = nx_cells.size_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TOKEN;
            r_kind   <= KIND_NONE;
            r_words  <= '0;
            r_left   <= '0;
            r_long   <= 1'b0;
            r_ended  <= 1'b0;
            r_failed <= 1'b0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_words  <= n_words;
            r_left   <= n_left;
            r_long   <= n_long;
            r_ended  <= n_ended;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_ofs <= '0;
            r_size_ofs <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ADDR_OFS: r_addr_ofs <= i_cfg_data;
                REG_SIZE_OFS: r_size_ofs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // two-entry result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (in_acc) begin
                r_wp <= ~r_wp;
            end
            if (out_acc) begin
                r_rp <= ~r_rp;
            end
            if (in_acc && !out_acc) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!in_acc && out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q[r_wp] <= res;
        end
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q[r_rp];
    assign o_cfg_ready = 1'b1;

endmodule

### rtl/fdtw_cell_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtw_cell_stack
// Stack of address/size cell counts. The current and parent levels sit in
// registers; older levels live in a synchronous memory that is read ahead.
// ----------------------------------------------------------------------------
module fdtw_cell_stack #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fdtw_pkg::t_stk_op            i_op,
    output logic [$clog2(MAX_DEPTH)-1:0] o_depth,
    output logic [$clog2(MAX_DEPTH)-1:0] o_next_depth,
    output fdtw_pkg::t_cells             o_next_cells
);
    import fdtw_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH);

    logic [DW-1:0] r_depth, n_depth;
    t_cells        r_top, n_top;
    t_cells        r_below, n_below;
    t_cells        r_rdata;
    t_cells        mem [MAX_DEPTH];

    logic [DW-1:0] e_depth;
    t_cells        e_top, e_below;
    logic          mem_we;
    logic [DW-1:0] mem_wa, mem_ra;
    t_cells        mem_wd;

    always_comb begin
        e_depth = i_op.clear ? '0 : r_depth;
        e_top   = i_op.clear ? '0 : r_top;
        e_below = i_op.clear ? '0 : r_below;

        n_depth = e_depth;
        n_top   = e_top;
        n_below = e_below;
        mem_we  = 1'b0;
        mem_wa  = e_depth - DW'(1);
        mem_wd  = e_below;

        if (i_op.push) begin
            // spill the parent level, child inherits the current counts
            n_depth = e_depth + DW'(1);
            n_below = e_top;
            mem_we  = (e_depth != '0);
        end else if (i_op.pop) begin
            n_depth = e_depth - DW'(1);
            n_top   = e_below;
            n_below = r_rdata;
        end else if (i_op.set_addr) begin
            n_top.addr_cnt = i_op.value;
        end else if (i_op.set_size) begin
            n_top.size_cnt = i_op.value;
        end

        // prefetch the level below the next parent
        mem_ra = n_depth - DW'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_top   <= '0;
            r_below <= '0;
        end else begin
            r_depth <= n_depth;
            r_top   <= n_top;
            r_below <= n_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        // forward a write to the entry being read
        if (mem_we && (mem_wa == mem_ra)) begin
            r_rdata <= mem_wd;
        end else begin
            r_rdata <= mem[mem_ra];
        end
    end

    assign o_depth      = r_depth;
    assign o_next_depth = n_depth;
    assign o_next_cells = n_top;

endmodule

### bench/tb_fdt_struct_token_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fdt_struct_token_walker
// Self-checking bench for the device-tree structure-block token walker.
// ----------------------------------------------------------------------------
// A queue of words and register writes is built up front: a short directed
// block, then mostly well-formed trees with random names, properties and
// cell values, mixed with deep chains, bad tokens, huge property lengths and
// raw noise. A clocked driver feeds the queue with random gaps and a clocked
// monitor takes results with random stalls, including long hold-offs.
// Each accepted word is run through a local walker model and the result is
// compared with what the block returns, field by field.
// ----------------------------------------------------------------------------
module tb_fdt_struct_token_walker;
    import fdtw_pkg::*;

    localparam int MAX_DEPTH      = 16;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_COUNT    = 6;
    localparam int TOTAL_WORDS    = 1900;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [2:0] {
        WALK_TOKEN,
        WALK_NAME,
        WALK_LEN,
        WALK_OFS,
        WALK_DATA
    } t_walk_phase;

    typedef enum logic [1:0] {
        CELLS_NONE,
        CELLS_ADDR,
        CELLS_SIZE
    } t_cells_kind;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          value;
        t_in_item             item;
    } t_feed;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid_r  = 1'b0;
    t_in_item             in_data_r   = '0;
    logic                 out_ready_r = 1'b0;
    logic                 cfg_valid_r = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx_r   = '0;
    logic [31:0]          cfg_data_r  = '0;

    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    t_feed     word_feed[$];
    t_out_item walk_results_q[$];
    int        err_count = 0;

    // Walker model state
    t_walk_phase w_phase;
    int unsigned w_depth;
    logic [7:0]  w_addr_stk [MAX_DEPTH];
    logic [7:0]  w_size_stk [MAX_DEPTH];
    logic [31:0] w_left;
    logic [31:0] w_len;
    t_cells_kind w_kind;
    logic        w_ended;
    logic        w_failed;
    logic [31:0] cfg_addr_ofs;
    logic [31:0] cfg_size_ofs;

    // Offsets in force while the stimulus is built
    logic [31:0] gen_addr_ofs;
    logic [31:0] gen_size_ofs;
    logic        first_pending;

    fdt_struct_token_walker #(.MAX_DEPTH(MAX_DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid_r),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data_r),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready_r),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid_r),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx_r),
        .i_cfg_data  (cfg_data_r)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_walk();
        w_phase  = WALK_TOKEN;
        w_depth  = 0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            w_addr_stk[i] = 8'd0;
            w_size_stk[i] = 8'd0;
        end
        w_left   = '0;
        w_len    = '0;
        w_kind   = CELLS_NONE;
        w_ended  = 1'b0;
        w_failed = 1'b0;
    endfunction

    function automatic void write_offset(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        if (idx == REG_ADDR_OFS) begin
            cfg_addr_ofs = value;
        end else if (idx == REG_SIZE_OFS) begin
            cfg_size_ofs = value;
        end
    endfunction

    // Advance the walker by one word and return the result it gives
    function automatic t_out_item walk_word(t_in_item it);
        logic [2:0] ev;
        logic [7:0] v;
        t_out_item  res;
        ev = EV_NONE;
        if (it.first_word) begin
            clear_walk();
        end
        if (w_failed) begin
            ev = EV_BAD_TOKEN;
        end else if (w_ended) begin
            ev = EV_AFTER_END;
        end else begin
            case (w_phase)
                WALK_NAME: begin
                    if (it.word[7:0] == 8'd0 || it.word[15:8] == 8'd0 ||
                        it.word[23:16] == 8'd0 || it.word[31:24] == 8'd0) begin
                        w_phase = WALK_TOKEN;
                    end
                end
                WALK_LEN: begin
                    w_len   = it.word;
                    w_phase = WALK_OFS;
                end
                WALK_OFS: begin
                    if (it.word == cfg_addr_ofs) begin
                        w_kind = CELLS_ADDR;
                    end else if (it.word == cfg_size_ofs) begin
                        w_kind = CELLS_SIZE;
                    end else begin
                        w_kind = CELLS_NONE;
                    end
                    w_left = {2'b00, w_len[31:2]} + ((w_len[1:0] != 2'b00) ? 32'd1 : 32'd0);
                    if (w_left == 32'd0) begin
                        w_phase = WALK_TOKEN;
                        w_kind  = CELLS_NONE;
                    end else begin
                        w_phase = WALK_DATA;
                    end
                end
                WALK_DATA: begin
                    // Only the first data word of a long enough property counts
                    if (w_kind != CELLS_NONE && w_len >= 32'd4) begin
                        v = (it.word > 32'd255) ? 8'hFF : it.word[7:0];
                        if (w_kind == CELLS_ADDR) begin
                            w_addr_stk[w_depth] = v;
                        end else begin
                            w_size_stk[w_depth] = v;
                        end
                    end
                    w_kind = CELLS_NONE;
                    w_left = w_left - 32'd1;
                    if (w_left == 32'd0) begin
                        w_phase = WALK_TOKEN;
                    end
                end
                default: begin
                    w_phase = WALK_TOKEN;
                    case (it.word)
                        TOK_BEGIN_NODE: begin
                            if (w_depth >= MAX_DEPTH - 1) begin
                                w_failed = 1'b1;
                                ev       = EV_OVERFLOW;
                            end else begin
                                w_addr_stk[w_depth + 1] = w_addr_stk[w_depth];
                                w_size_stk[w_depth + 1] = w_size_stk[w_depth];
                                w_depth = w_depth + 1;
                                w_phase = WALK_NAME;
                                ev      = EV_NODE_BEG;
                            end
                        end
                        TOK_END_NODE: begin
                            if (w_depth == 0) begin
                                w_failed = 1'b1;
                                ev       = EV_BAD_TOKEN;
                            end else begin
                                w_depth = w_depth - 1;
                                ev      = EV_NODE_END;
                            end
                        end
                        TOK_PROP: begin
                            w_phase = WALK_LEN;
                            ev      = EV_PROP;
                        end
                        TOK_NOP: begin
                        end
                        TOK_END: begin
                            w_ended = 1'b1;
                            ev      = EV_END;
                        end
                        default: begin
                            w_failed = 1'b1;
                            ev       = EV_BAD_TOKEN;
                        end
                    endcase
                end
            endcase
        end
        res.token_event = ev;
        res.tree_depth  = w_depth[3:0];
        res.addr_cnt    = w_addr_stk[w_depth];
        res.size_cnt    = w_size_stk[w_depth];
        return res;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- stimulus building ----------------

    task automatic push_word(logic [31:0] w);
        t_feed f;
        f                 = '0;
        f.item.word       = w;
        f.item.first_word = first_pending;
        first_pending     = 1'b0;
        word_feed.push_back(f);
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        t_feed f;
        f        = '0;
        f.is_cfg = 1'b1;
        f.idx    = idx;
        f.value  = value;
        word_feed.push_back(f);
        if (idx == REG_ADDR_OFS) begin
            gen_addr_ofs = value;
        end else if (idx == REG_SIZE_OFS) begin
            gen_size_ofs = value;
        end
    endtask

    function automatic logic [31:0] name_word_nz();
        logic [31:0] w;
        for (int k = 0; k < 4; k++) begin
            w[8*k +: 8] = 8'($urandom_range(1, 255));
        end
        return w;
    endfunction

    function automatic logic [31:0] name_word_z();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            w = 32'd0;
        end else begin
            w[8*$urandom_range(0, 3) +: 8] = 8'd0;
        end
        return w;
    endfunction

    function automatic logic [31:0] pick_offset();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) return gen_addr_ofs;
        if (r < 6) return gen_size_ofs;
        if (r < 7) return gen_addr_ofs + 32'd1;
        return $urandom;
    endfunction

    function automatic logic [31:0] cell_value();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r < 2) return $urandom_range(0, 8);
        if (r < 3) return $urandom_range(250, 260);
        return $urandom;
    endfunction

    task automatic gen_name();
        repeat ($urandom_range(0, 3)) push_word(name_word_nz());
        push_word(name_word_z());
    endtask

    task automatic gen_prop();
        logic [31:0] len;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            len = 32'd4;
        end else if (r < 4) begin
            len = $urandom_range(1, 3);
        end else if (r < 5) begin
            len = 32'd0;
        end else begin
            len = $urandom_range(5, 16);
        end
        push_word(TOK_PROP);
        push_word(len);
        push_word(pick_offset());
        for (int i = 0; i < (len + 3) / 4; i++) begin
            push_word((i == 0) ? cell_value() : $urandom);
        end
    endtask

    task automatic gen_node(int lvl);
        int unsigned kids;
        push_word(TOK_BEGIN_NODE);
        gen_name();
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 4) == 0) push_word(TOK_NOP);
            else gen_prop();
        end
        kids = (lvl < 3) ? $urandom_range(0, 2) : 0;
        repeat (kids) gen_node(lvl + 1);
        if ($urandom_range(0, 5) == 0) push_word(TOK_NOP);
        push_word(TOK_END_NODE);
    endtask

    task automatic gen_tree();
        first_pending = 1'b1;
        if ($urandom_range(0, 4) == 0) push_word(TOK_NOP);
        // properties outside any node land on stack entry zero
        if ($urandom_range(0, 4) == 0) gen_prop();
        gen_node(0);
        if ($urandom_range(0, 5) == 0) gen_prop();
        push_word(TOK_END);
        repeat ($urandom_range(0, 2)) push_word($urandom);
    endtask

    task automatic gen_deep();
        first_pending = 1'b1;
        repeat (MAX_DEPTH - 1) begin
            push_word(TOK_BEGIN_NODE);
            push_word(name_word_z());
            if ($urandom_range(0, 3) == 0) gen_prop();
        end
        if ($urandom_range(0, 1) == 0) begin
            // one level too many: sticky overflow
            push_word(TOK_BEGIN_NODE);
            repeat ($urandom_range(1, 3)) push_word($urandom);
        end else begin
            gen_prop();
            repeat (MAX_DEPTH - 1) push_word(TOK_END_NODE);
            push_word(TOK_END);
        end
    endtask

    task automatic gen_broken();
        int unsigned r;
        first_pending = 1'b1;
        push_word(TOK_BEGIN_NODE);
        gen_name();
        if ($urandom_range(0, 1) == 0) gen_prop();
        r = $urandom_range(0, 7);
        case (r)
            0: push_word(32'd0);
            1: push_word(32'd5);
            2: push_word(32'd8);
            3: push_word(32'd10);
            4: begin
                // close more nodes than were opened
                push_word(TOK_END_NODE);
                push_word(TOK_END_NODE);
            end
            default: push_word($urandom);
        endcase
        repeat ($urandom_range(1, 3)) push_word($urandom);
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 6)) begin
            first_pending = ($urandom_range(0, 3) == 0);
            push_word($urandom);
        end
    endtask

    task automatic gen_huge_prop();
        logic [31:0] len;
        case ($urandom_range(0, 4))
            0: len = 32'hFFFF_FFFF;
            1: len = 32'hFFFF_FFFC;
            2: len = 32'hFFFF_FFFD;
            3: len = 32'h8000_0001;
            default: len = $urandom | 32'h8000_0000;
        endcase
        first_pending = 1'b1;
        push_word(TOK_BEGIN_NODE);
        gen_name();
        push_word(TOK_PROP);
        push_word(len);
        push_word(pick_offset());
        repeat ($urandom_range(1, 4)) push_word(cell_value());
    endtask

    task automatic build_directed();
        first_pending = 1'b1;
        // property outside any node, empty
        push_word(TOK_PROP);
        push_word(32'd0);
        push_word(32'd0);
        push_word(TOK_BEGIN_NODE);
        push_word(32'h2F00_0000);
        // saturating address-cell update
        push_word(TOK_PROP);
        push_word(32'd4);
        push_word(32'd0);
        push_word(32'hFFFF_FFFF);
        // short matching property leaves the counts alone
        push_word(TOK_PROP);
        push_word(32'd2);
        push_word(32'd0);
        push_word(32'd5);
        push_word(TOK_BEGIN_NODE);
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(TOK_NOP);
        push_word(TOK_END_NODE);
        push_word(TOK_END_NODE);
        // end-node at depth zero fails, then stays failed
        push_word(TOK_END_NODE);
        push_word(32'h1234_5678);
        first_pending = 1'b1;
        push_word(TOK_END);
        push_word(32'hDEAD_BEEF);
        first_pending = 1'b1;
        push_word(32'd7);
    endtask

    task automatic build_stimulus();
        int unsigned r;
        logic [31:0] shared;
        gen_addr_ofs  = 32'd0;
        gen_size_ofs  = 32'd0;
        first_pending = 1'b0;
        build_directed();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    push_cfg(REG_ADDR_OFS, 32'h0000_0010);
                    push_cfg(REG_SIZE_OFS, 32'h0000_001C);
                end
                1: begin
                    push_cfg(REG_ADDR_OFS, 32'hFFFF_FFFF);
                    push_cfg(REG_SIZE_OFS, 32'h0000_0000);
                end
                2: begin
                    push_cfg(REG_ADDR_OFS, 32'h0000_0000);
                    push_cfg(REG_SIZE_OFS, 32'hFFFF_FFFF);
                end
                3: begin
                    push_cfg(REG_ADDR_OFS, $urandom);
                    push_cfg(REG_SIZE_OFS, $urandom);
                end
                4: begin
                    // equal offsets: a match counts as address cells
                    shared = $urandom;
                    push_cfg(REG_ADDR_OFS, shared);
                    push_cfg(REG_SIZE_OFS, shared);
                end
                default: begin
                    push_cfg(REG_ADDR_OFS, 32'h0000_0020);
                    push_cfg(REG_SIZE_OFS, 32'h0000_002C);
                    push_cfg(REG_SPARE_A, $urandom);
                    push_cfg(REG_SPARE_B, $urandom);
                end
            endcase
            if (ph == 0) gen_deep();
            while (word_feed.size() < (TOTAL_WORDS * (ph + 1)) / PHASE_COUNT) begin
                r = $urandom_range(0, 99);
                if (r < 68) gen_tree();
                else if (r < 76) gen_deep();
                else if (r < 86) gen_noise();
                else if (r < 94) gen_broken();
                else gen_huge_prop();
            end
        end
    endtask

    // ---------------- driver ----------------

    int unsigned send_gap  = 0;
    int unsigned send_calm = 0;
    int unsigned quiet     = 0;

    always @(posedge i_clk) begin : drive_proc
        logic  hold_in;
        logic  hold_cfg;
        t_feed head;
        if (!rst_n) begin
            in_valid_r  <= 1'b0;
            cfg_valid_r <= 1'b0;
            send_gap    <= 0;
            send_calm   <= 0;
            quiet       <= 0;
        end else begin
            hold_in  = in_valid_r;
            hold_cfg = cfg_valid_r;
            if (in_valid_r && o_in_ready) begin
                walk_results_q.push_back(walk_word(in_data_r));
                hold_in = 1'b0;
            end
            if (cfg_valid_r && o_cfg_ready) begin
                write_offset(cfg_idx_r, cfg_data_r);
                hold_cfg = 1'b0;
            end
            if (walk_results_q.size() == 0 && !in_valid_r && !o_out_valid) begin
                quiet <= quiet + 1;
            end else begin
                quiet <= 0;
            end
            if (!hold_in && !hold_cfg) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else if (word_feed.size() != 0) begin
                    head = word_feed[0];
                    if (head.is_cfg) begin
                        // write registers only once the walker has gone quiet
                        if (quiet >= SETTLE_CYCLES) begin
                            head       = word_feed.pop_front();
                            cfg_idx_r  <= head.idx;
                            cfg_data_r <= head.value;
                            hold_cfg   = 1'b1;
                        end
                    end else begin
                        head      = word_feed.pop_front();
                        in_data_r <= head.item;
                        hold_in   = 1'b1;
                        if (send_calm != 0) begin
                            send_calm <= send_calm - 1;
                            send_gap  <= 0;
                        end else begin
                            if ($urandom_range(0, 19) == 0) send_calm <= $urandom_range(30, 150);
                            send_gap <= idle_len();
                        end
                    end
                end
            end
            in_valid_r  <= hold_in;
            cfg_valid_r <= hold_cfg;
        end
    end

    // ---------------- monitor ----------------

    int unsigned stall_left = 0;
    int unsigned recv_calm  = 0;
    int unsigned hold_left  = 0;
    int unsigned seen       = 0;
    int unsigned hold_at    = 400;

    always @(posedge i_clk) begin : check_proc
        t_out_item   want;
        int unsigned g;
        if (!rst_n) begin
            out_ready_r <= 1'b0;
            stall_left  <= 0;
            recv_calm   <= 0;
            hold_left   <= 0;
            seen        <= 0;
            hold_at     <= 400;
        end else begin
            if (o_out_valid && out_ready_r) begin
                seen <= seen + 1;
                if (walk_results_q.size() == 0) begin
                    if (err_count < 10) begin
                        $display("%0t: result with nothing pending: ev %0d depth %0d a %0d s %0d",
                                 $realtime, o_out_data.token_event, o_out_data.tree_depth,
                                 o_out_data.addr_cnt, o_out_data.size_cnt);
                    end
                    err_count <= err_count + 1;
                end else begin
                    want = walk_results_q.pop_front();
                    if (o_out_data.token_event !== want.token_event ||
                        o_out_data.tree_depth  !== want.tree_depth  ||
                        o_out_data.addr_cnt    !== want.addr_cnt    ||
                        o_out_data.size_cnt    !== want.size_cnt) begin
                        if (err_count < 10) begin
                            $display("%0t: mismatch ev %0d/%0d depth %0d/%0d a %0d/%0d s %0d/%0d",
                                     $realtime, want.token_event, o_out_data.token_event,
                                     want.tree_depth, o_out_data.tree_depth,
                                     want.addr_cnt, o_out_data.addr_cnt,
                                     want.size_cnt, o_out_data.size_cnt);
                        end
                        err_count <= err_count + 1;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                out_ready_r <= (hold_left == 1);
            end else if (seen >= hold_at) begin
                // long hold-off: let the walker fill up and stall its input
                hold_left   <= HOLD_CYCLES;
                hold_at     <= hold_at + 900;
                out_ready_r <= 1'b0;
            end else if (o_out_valid && out_ready_r) begin
                if (recv_calm != 0) begin
                    recv_calm <= recv_calm - 1;
                    g = 0;
                end else begin
                    if ($urandom_range(0, 19) == 0) recv_calm <= $urandom_range(30, 150);
                    g = idle_len();
                end
                stall_left  <= g;
                out_ready_r <= (g == 0);
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                out_ready_r <= (stall_left == 1);
            end else begin
                out_ready_r <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------

    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog_proc
        if (!rst_n || (in_valid_r && o_in_ready) || (o_out_valid && out_ready_r) ||
            (cfg_valid_r && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_walk();
        cfg_addr_ofs = 32'd0;
        cfg_size_ofs = 32'd0;
        build_stimulus();
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        while (word_feed.size() != 0 || in_valid_r || cfg_valid_r ||
               walk_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && walk_results_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/fdtw_pkg.sv
rtl/fdtw_cell_stack.sv
rtl/fdt_struct_token_walker.sv
bench/tb_fdt_struct_token_walker.sv
